// File: rtl/core/wacu_pkg.sv
// Package for the wavetable audio channel unit.
// Holds command codes, register selects, widths and shared types.
// No dependencies.
`default_nettype none

package wacu_pkg;

    localparam int unsigned LENGTH_LIMIT_DEF = 256;
    localparam int unsigned WAVE_BYTES       = 16;
    localparam int unsigned WAVE_AW          = $clog2(WAVE_BYTES);

    localparam logic [11:0] PERIOD_SPAN = 12'd2048;

    localparam logic signed [13:0] SAMPLE_CENTRE = 14'sd8;
    localparam logic signed [13:0] SAMPLE_SCALE  = 14'sd600;

    typedef enum logic [1:0] {
        CMD_PERIOD = 2'd0,
        CMD_LENGTH = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    localparam logic [2:0] SEL_CTRL0 = 3'd0;
    localparam logic [2:0] SEL_CTRL1 = 3'd1;
    localparam logic [2:0] SEL_CTRL2 = 3'd2;
    localparam logic [2:0] SEL_CTRL3 = 3'd3;
    localparam logic [2:0] SEL_CTRL4 = 3'd4;
    localparam logic [2:0] SEL_WAVE  = 3'd5;

    typedef struct packed {
        logic       dac_on;
        logic       channel_on;
        logic [1:0] volume_code;
        logic       nib_low;
    } sample_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/wacu_wave_ram.sv
// Wave RAM: 16 bytes, one write port, two registered read ports.
// Per-entry valid bits give the cleared state after reset. Uses wacu_pkg.
`default_nettype none

module wacu_wave_ram
    import wacu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [WAVE_AW-1:0] wr_addr,
    input  wire logic [7:0]         wr_data,
    input  wire logic               rd_en,
    input  wire logic [WAVE_AW-1:0] rd_addr_a,
    input  wire logic [WAVE_AW-1:0] rd_addr_b,
    output logic [7:0]              rd_data_a,
    output logic [7:0]              rd_data_b
);

    logic [7:0]            mem [WAVE_BYTES];
    logic [WAVE_BYTES-1:0] valid_reg;
    logic [7:0]            data_a_reg;
    logic [7:0]            data_b_reg;
    logic                  valid_a_reg;
    logic                  valid_b_reg;
    logic                  hit_b;

    assign hit_b = wr_en && (wr_addr == rd_addr_b);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= hit_b ? wr_data : mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= hit_b || valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : 8'd0;
    assign rd_data_b = valid_b_reg ? data_b_reg : 8'd0;

endmodule

`default_nettype wire

// File: rtl/core/wacu_regs.sv
// Control state: period divider, sample index, length counter, control registers.
// Applies one command per step and gives register read-back. Uses wacu_pkg.
`default_nettype none

module wacu_regs
    import wacu_pkg::*;
#(
    parameter int unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [1:0]         cmd,
    input  wire logic [2:0]         sel,
    input  wire logic [7:0]         data,
    output logic [7:0]              ctrl_rd,
    output logic [WAVE_AW-1:0]      wave_addr,
    output sample_ctl_t             sample_ctl
);

    localparam int unsigned LEN_RAW = $clog2(LENGTH_LIMIT + 1);
    localparam int unsigned LEN_W   = (LEN_RAW > 8) ? LEN_RAW : 8;
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(LENGTH_LIMIT);

    logic [4:0]       index_reg,   index_next;
    logic [11:0]      counter_reg, counter_next;
    logic [10:0]      period_reg,  period_next;
    logic [1:0]       volume_reg,  volume_next;
    logic             dac_reg,     dac_next;
    logic             chan_reg,    chan_next;
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [7:0]       reload_reg,  reload_next;
    logic             len_en_reg,  len_en_next;
    logic             trig_reg,    trig_next;

    logic [11:0]      threshold;
    logic [11:0]      counter_inc;
    logic [LEN_W-1:0] len_tmp;

    assign threshold   = (PERIOD_SPAN - {1'b0, period_reg}) >> 1;
    assign counter_inc = counter_reg + 12'd1;

    always_comb
    begin
        index_next   = index_reg;
        counter_next = counter_reg;
        period_next  = period_reg;
        volume_next  = volume_reg;
        dac_next     = dac_reg;
        chan_next    = chan_reg;
        len_next     = len_reg;
        reload_next  = reload_reg;
        len_en_next  = len_en_reg;
        trig_next    = trig_reg;
        len_tmp      = len_reg;
        case (cmd_t'(cmd))
            CMD_PERIOD:
            begin
                if (counter_inc >= threshold)
                begin
                    counter_next = 12'd0;
                    index_next   = index_reg + 5'd1;
                end
                else
                begin
                    counter_next = counter_inc;
                end
            end
            CMD_LENGTH:
            begin
                if (len_en_reg)
                begin
                    if (len_reg < LIMIT)
                    begin
                        len_tmp = len_reg + LEN_W'(1);
                    end
                    len_next = len_tmp;
                    if (len_tmp >= LIMIT)
                    begin
                        chan_next = 1'b0;
                    end
                end
            end
            CMD_WRITE:
            begin
                case (sel)
                    SEL_CTRL0:
                    begin
                        dac_next = data[7];
                        if (!data[7])
                        begin
                            chan_next = 1'b0;
                        end
                    end
                    SEL_CTRL1: reload_next = data;
                    SEL_CTRL2: volume_next = data[6:5];
                    SEL_CTRL3: period_next = {period_reg[10:8], data};
                    SEL_CTRL4:
                    begin
                        period_next = {data[2:0], period_reg[7:0]};
                        len_en_next = data[6];
                        trig_next   = data[7];
                        if (data[7])
                        begin
                            chan_next    = 1'b1;
                            counter_next = {1'b0, data[2:0], period_reg[7:0]};
                            if (len_reg >= LIMIT)
                            begin
                                len_next = LEN_W'(reload_reg);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ctrl_rd = 8'd0;
        if (cmd_t'(cmd) == CMD_READ)
        begin
            case (sel)
                SEL_CTRL0: ctrl_rd = {dac_reg, 7'd0};
                SEL_CTRL1: ctrl_rd = reload_reg;
                SEL_CTRL2: ctrl_rd = {1'b0, volume_reg, 5'd0};
                SEL_CTRL3: ctrl_rd = period_reg[7:0];
                SEL_CTRL4: ctrl_rd = {trig_reg, len_en_reg, 3'd0, period_reg[10:8]};
                default:   ctrl_rd = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            counter_reg <= '0;
            period_reg  <= '0;
            volume_reg  <= '0;
            dac_reg     <= 1'b0;
            chan_reg    <= 1'b0;
            len_reg     <= '0;
            reload_reg  <= '0;
            len_en_reg  <= 1'b0;
            trig_reg    <= 1'b0;
        end
        else if (step)
        begin
            index_reg   <= index_next;
            counter_reg <= counter_next;
            period_reg  <= period_next;
            volume_reg  <= volume_next;
            dac_reg     <= dac_next;
            chan_reg    <= chan_next;
            len_reg     <= len_next;
            reload_reg  <= reload_next;
            len_en_reg  <= len_en_next;
            trig_reg    <= trig_next;
        end
    end

    assign wave_addr              = index_next[4:1];
    assign sample_ctl.dac_on      = dac_reg;
    assign sample_ctl.channel_on  = chan_reg;
    assign sample_ctl.volume_code = volume_reg;
    assign sample_ctl.nib_low     = index_reg[0];

endmodule

`default_nettype wire

// File: rtl/core/wacu_mix.sv
// Result formation: read data select and sample scaling.
// Nibble pick, volume shift, centring and scale by 600. Uses wacu_pkg.
`default_nettype none

module wacu_mix
    import wacu_pkg::*;
(
    input  wire logic        rd_wave,
    input  wire logic [7:0]  ctrl_rd,
    input  wire logic [7:0]  wave_rd,
    input  wire logic [7:0]  wave_byte,
    input  wire sample_ctl_t sample_ctl,
    output logic [7:0]       read_data,
    output logic signed [13:0] sample
);

    logic [3:0]         nib;
    logic [3:0]         level;
    logic signed [13:0] centred;

    assign read_data = rd_wave ? wave_rd : ctrl_rd;
    assign nib       = sample_ctl.nib_low ? wave_byte[3:0] : wave_byte[7:4];

    always_comb
    begin
        case (sample_ctl.volume_code)
            2'd1:    level = nib;
            2'd2:    level = nib >> 1;
            2'd3:    level = nib >> 2;
            default: level = 4'd0;
        endcase
    end

    assign centred = $signed({10'd0, level}) - SAMPLE_CENTRE;

    always_comb
    begin
        if (sample_ctl.dac_on && sample_ctl.channel_on)
        begin
            sample = centred * SAMPLE_SCALE;
        end
        else
        begin
            sample = 14'sd0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wavetable_audio_channel_unit.sv
// Wavetable audio channel unit: top level with the three-stage beat pipeline.
// Instantiates wacu_regs, wacu_wave_ram and wacu_mix. Uses wacu_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat: period
//   tick, length tick, register write or register read, with reg_select,
//   ram_offset and write_data. Output channel (out_valid/out_ready) returns
//   exactly one beat per command: read_data (zero unless a read) and
//   sample_out, the channel sample after the command has taken effect.
//   Each command passes the input register, the wave RAM read register and
//   the output register. Throughput: one command per cycle unless the receiver
//   stalls, set by the state update as a command leaves the input register.
//   Reset clears all control state and marks every wave RAM byte as zero;
//   the block accepts beats from the first cycle after reset.
//   When the receiver stalls, results hold in the output register and the
//   pipeline fills; in_ready falls only once all three stages are full.
`default_nettype none

module wavetable_audio_channel_unit
    import wacu_pkg::*;
#(
    parameter int unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  reg_select,
    input  wire logic [3:0]  ram_offset,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_data,
    output logic signed [13:0] sample_out
);

    logic               s1_valid_reg;
    logic [1:0]         s1_cmd_reg;
    logic [2:0]         s1_sel_reg;
    logic [3:0]         s1_off_reg;
    logic [7:0]         s1_data_reg;

    logic               s2_valid_reg;
    logic               s2_rd_wave_reg;
    logic [7:0]         s2_ctrl_rd_reg;

    logic               out_valid_reg;
    logic [7:0]         read_data_reg;
    logic signed [13:0] sample_reg;

    logic               out_free;
    logic               s2_move;
    logic               s1_move;
    logic               in_take;
    logic               wave_wr;

    logic [7:0]         ctrl_rd;
    logic [WAVE_AW-1:0] wave_addr;
    sample_ctl_t        sample_ctl;
    logic [7:0]         wave_rd;
    logic [7:0]         wave_byte;
    logic [7:0]         read_data_next;
    logic signed [13:0] sample_next;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_move  = s2_valid_reg && out_free;
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;
    assign wave_wr  = s1_move && (cmd_t'(s1_cmd_reg) == CMD_WRITE) && (s1_sel_reg == SEL_WAVE);

    wacu_regs #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_move),
        .cmd        (s1_cmd_reg),
        .sel        (s1_sel_reg),
        .data       (s1_data_reg),
        .ctrl_rd    (ctrl_rd),
        .wave_addr  (wave_addr),
        .sample_ctl (sample_ctl)
    );

    wacu_wave_ram u_wave_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wave_wr),
        .wr_addr   (s1_off_reg),
        .wr_data   (s1_data_reg),
        .rd_en     (s1_move),
        .rd_addr_a (s1_off_reg),
        .rd_addr_b (wave_addr),
        .rd_data_a (wave_rd),
        .rd_data_b (wave_byte)
    );

    wacu_mix u_mix (
        .rd_wave    (s2_rd_wave_reg),
        .ctrl_rd    (s2_ctrl_rd_reg),
        .wave_rd    (wave_rd),
        .wave_byte  (wave_byte),
        .sample_ctl (sample_ctl),
        .read_data  (read_data_next),
        .sample     (sample_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_valid_reg || s2_move)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= command;
            s1_sel_reg  <= reg_select;
            s1_off_reg  <= ram_offset;
            s1_data_reg <= write_data;
        end
        if (s1_move)
        begin
            s2_rd_wave_reg <= (cmd_t'(s1_cmd_reg) == CMD_READ) && (s1_sel_reg == SEL_WAVE);
            s2_ctrl_rd_reg <= ctrl_rd;
        end
        if (s2_move)
        begin
            read_data_reg <= read_data_next;
            sample_reg    <= sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign sample_out = sample_reg;

endmodule

`default_nettype wire

// File: bench/wacu_checker.sv
// Checker for the wavetable audio channel unit: watches both beat channels,
// predicts each result from its own copy of the channel state and compares.
// Depends on wacu_pkg.
`default_nettype none

module wacu_checker
    import wacu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         command,
    input  wire logic [2:0]         reg_select,
    input  wire logic [3:0]         ram_offset,
    input  wire logic [7:0]         write_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [7:0]         read_data,
    input  wire logic signed [13:0] sample_out,
    output int unsigned             fail_count,
    output int unsigned             waiting
);

    typedef struct packed {
        logic [7:0]         rd;
        logic signed [13:0] smp;
    } channel_beat_t;

    channel_beat_t results_due[$];
    channel_beat_t due_beat;
    channel_beat_t new_beat;

    logic [7:0]  wave_mem [WAVE_BYTES];
    logic [4:0]  idx_r;
    logic [11:0] div_r;
    logic [10:0] period_r;
    logic [1:0]  vol_r;
    logic        dac_r;
    logic        chan_r;
    logic [8:0]  len_r;
    logic [7:0]  reload_r;
    logic        len_en_r;
    logic        trig_r;

    initial
    begin
        fail_count = 0;
        waiting    = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 40)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic signed [13:0] channel_level();
        logic [7:0] byte_val;
        logic [3:0] nib;
        int         lvl;
        if (!dac_r || !chan_r)
            return '0;
        byte_val = wave_mem[idx_r[4:1]];
        nib = idx_r[0] ? byte_val[3:0] : byte_val[7:4];
        if (vol_r == 2'd0)
            nib = 4'd0;
        else
            nib = nib >> (vol_r - 2'd1);
        lvl = (int'(nib) - int'(SAMPLE_CENTRE)) * int'(SAMPLE_SCALE);
        return lvl[13:0];
    endfunction

    task automatic fire_trigger();
        chan_r = 1'b1;
        if (len_r >= LENGTH_LIMIT_DEF)
            len_r = {1'b0, reload_r};
        div_r = {1'b0, period_r};
    endtask

    task automatic apply_command(input cmd_t cmd, input logic [2:0] sel,
                                 input logic [3:0] off, input logic [7:0] data,
                                 output channel_beat_t res);
        logic [11:0] thr;
        res.rd = 8'h00;
        case (cmd)
            CMD_PERIOD:
            begin
                thr   = (PERIOD_SPAN - {1'b0, period_r}) >> 1;
                div_r = div_r + 12'd1;
                if (div_r >= thr)
                begin
                    div_r = '0;
                    idx_r = idx_r + 5'd1;
                end
            end
            CMD_LENGTH:
            begin
                if (len_en_r)
                begin
                    if (len_r < LENGTH_LIMIT_DEF)
                        len_r = len_r + 9'd1;
                    if (len_r >= LENGTH_LIMIT_DEF)
                        chan_r = 1'b0;
                end
            end
            CMD_WRITE:
            begin
                case (sel)
                    SEL_CTRL0:
                    begin
                        dac_r = data[7];
                        if (!dac_r)
                            chan_r = 1'b0;
                    end
                    SEL_CTRL1: reload_r = data;
                    SEL_CTRL2: vol_r = data[6:5];
                    SEL_CTRL3: period_r[7:0] = data;
                    SEL_CTRL4:
                    begin
                        period_r[10:8] = data[2:0];
                        len_en_r       = data[6];
                        trig_r         = data[7];
                        if (trig_r)
                            fire_trigger();
                    end
                    SEL_WAVE: wave_mem[off] = data;
                    default: ;
                endcase
            end
            default:
            begin
                case (sel)
                    SEL_CTRL0: res.rd = {dac_r, 7'd0};
                    SEL_CTRL1: res.rd = reload_r;
                    SEL_CTRL2: res.rd = {1'b0, vol_r, 5'd0};
                    SEL_CTRL3: res.rd = period_r[7:0];
                    SEL_CTRL4: res.rd = {trig_r, len_en_r, 3'd0, period_r[10:8]};
                    SEL_WAVE:  res.rd = wave_mem[off];
                    default:   res.rd = 8'h00;
                endcase
            end
        endcase
        res.smp = channel_level();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (wave_mem[i])
                wave_mem[i] = '0;
            idx_r    = '0;
            div_r    = '0;
            period_r = '0;
            vol_r    = '0;
            dac_r    = 1'b0;
            chan_r   = 1'b0;
            len_r    = '0;
            reload_r = '0;
            len_en_r = 1'b0;
            trig_r   = 1'b0;
            results_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("result beat with none due: rd %h sample %0d",
                                              read_data, sample_out));
                else
                begin
                    due_beat = results_due.pop_front();
                    if (read_data !== due_beat.rd)
                        report_mismatch($sformatf("read_data %h, due %h",
                                                  read_data, due_beat.rd));
                    if (sample_out !== due_beat.smp)
                        report_mismatch($sformatf("sample_out %0d, due %0d",
                                                  sample_out, due_beat.smp));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_command(cmd_t'(command), reg_select, ram_offset, write_data, new_beat);
                results_due.push_back(new_beat);
            end
        end
        waiting <= results_due.size();
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench top for the wavetable audio channel unit: drives command beats,
// stalls the result side at random and gives the verdict.
// Depends on wacu_pkg, wavetable_audio_channel_unit and wacu_checker.
`default_nettype none

module tb;
    import wacu_pkg::*;

    localparam logic [2:0]  SEL_SPARE6  = 3'd6;
    localparam logic [2:0]  SEL_SPARE7  = 3'd7;
    localparam int unsigned QUIET_LIMIT = 5000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [1:0]         command    = '0;
    logic [2:0]         reg_select = '0;
    logic [3:0]         ram_offset = '0;
    logic [7:0]         write_data = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [7:0]         read_data;
    logic signed [13:0] sample_out;
    logic               steady     = 1'b0;
    int unsigned        fail_count;
    int unsigned        waiting;
    int unsigned        quiet_cycles = 0;

    wavetable_audio_channel_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .reg_select (reg_select),
        .ram_offset (ram_offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .sample_out (sample_out)
    );

    wacu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .reg_select (reg_select),
        .ram_offset (ram_offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .sample_out (sample_out),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 32);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input cmd_t cmd, input logic [2:0] sel,
                             input logic [3:0] off, input logic [7:0] data);
        if (!steady)
            while ($urandom_range(0, 99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        command    <= cmd;
        reg_select <= sel;
        ram_offset <= off;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         r;
        cmd_t       cmd;
        logic [2:0] sel;
        logic [7:0] data;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every selector read straight out of reset, spare ones included
        for (int s = 0; s < 8; s++)
            send_beat(CMD_READ, 3'(s), 4'(s), 8'h00);
        send_beat(CMD_WRITE, SEL_WAVE, 4'h0, 8'hF0);
        send_beat(CMD_WRITE, SEL_WAVE, 4'hF, 8'h0F);
        send_beat(CMD_WRITE, SEL_CTRL4, 4'h0, 8'h80);   // trigger, DAC still off
        send_beat(CMD_WRITE, SEL_CTRL0, 4'h0, 8'h80);
        send_beat(CMD_WRITE, SEL_CTRL2, 4'h0, 8'h20);
        send_beat(CMD_WRITE, SEL_CTRL3, 4'h0, 8'hFF);
        send_beat(CMD_WRITE, SEL_CTRL4, 4'h0, 8'hC7);   // preload above threshold
        send_beat(CMD_PERIOD, SEL_SPARE7, 4'hF, 8'hFF);
        send_beat(CMD_PERIOD, SEL_CTRL0, 4'h0, 8'h00);
        send_beat(CMD_WRITE, SEL_CTRL2, 4'h0, 8'h9F);   // mute, spare bits set
        send_beat(CMD_WRITE, SEL_SPARE6, 4'h3, 8'hFF);
        send_beat(CMD_WRITE, SEL_SPARE7, 4'hC, 8'hFF);
        send_beat(CMD_LENGTH, SEL_WAVE, 4'h5, 8'hA5);
        send_beat(CMD_READ, SEL_CTRL4, 4'h0, 8'h00);
        send_beat(CMD_WRITE, SEL_CTRL0, 4'h0, 8'h7F);   // DAC off kills channel
        drain();

        for (int i = 0; i < 265; i++)
        begin
            steady <= (i >= 150 && i < 230);
            if (i == 250)
                drain();
            if (i == 100)
            begin
                // run the length counter out, saturate it, then retrigger
                send_beat(CMD_WRITE, SEL_CTRL1, 4'(i), 8'hF8);
                send_beat(CMD_WRITE, SEL_CTRL0, 4'(i), 8'h80);
                send_beat(CMD_WRITE, SEL_CTRL4, 4'(i), 8'hC7);
                repeat (258)
                    send_beat(CMD_LENGTH, 3'($urandom_range(0, 7)),
                              4'($urandom_range(0, 15)), 8'($urandom));
                send_beat(CMD_READ, SEL_CTRL1, 4'(i), 8'h00);
                send_beat(CMD_WRITE, SEL_CTRL4, 4'(i), 8'hC6);
            end
            r    = $urandom_range(0, 99);
            sel  = 3'($urandom_range(0, 7));
            data = 8'($urandom);
            if (r < 40)
                cmd = CMD_PERIOD;
            else if (r < 55)
                cmd = CMD_LENGTH;
            else if (r < 78)
            begin
                cmd = CMD_WRITE;
                case (sel)
                    SEL_CTRL0: data[7] = ($urandom_range(0, 99) < 85);
                    SEL_CTRL1:
                        if ($urandom_range(0, 1) == 1)
                            data[7:4] = 4'hF;
                    SEL_CTRL4:
                        if ($urandom_range(0, 99) < 70)
                            data[2:0] = 3'h7;
                    default: ;
                endcase
            end
            else
                cmd = CMD_READ;
            send_beat(cmd, sel, 4'($urandom_range(0, 15)), data);
        end

        steady <= 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
